// ===== hdl/dha_pkg.sv =====
// shared types and codes for the decoder handle allocator
package dha_pkg;

   localparam int unsigned SLOT_IDX_W   = 8;
   localparam int unsigned OWNER_W      = 8;
   localparam int unsigned HANDLE_W     = 4;
   localparam int unsigned FIRST_HANDLE = 1;

   typedef enum logic [1:0] {
      OP_REGISTER = 2'd0,
      OP_DELETE   = 2'd1,
      OP_LOOKUP   = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_HANDLES = 2'd1,
      STATUS_BAD_HANDLE = 2'd2
   } status_type;

   typedef struct packed {
      logic                  mark;
      logic                  clear_one;
      logic                  clear_all;
      logic [SLOT_IDX_W-1:0] wr_idx;
      logic [OWNER_W-1:0]    wr_owner;
      logic [SLOT_IDX_W-1:0] rd_idx;
   } store_cmd_type;

   typedef struct packed {
      logic               owned;
      logic [OWNER_W-1:0] owner;
   } store_rsp_type;

endpackage

// ===== hdl/dha_slot_store.sv =====
// slot table: owned flags in flip-flops, owner ids in a memory with registered read
module dha_slot_store #(
   parameter int unsigned LAST_HANDLE = 15,
   localparam int unsigned SLOT_COUNT = LAST_HANDLE + 1,
   localparam int unsigned IDX_W      = $clog2(SLOT_COUNT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dha_pkg::store_cmd_type store_cmd,
   output dha_pkg::store_rsp_type store_rsp
);

   logic [SLOT_COUNT-1:0]        owned_ff;
   logic [SLOT_COUNT-1:0]        owned_in;
   logic [dha_pkg::OWNER_W-1:0]  owner_mem [SLOT_COUNT];
   logic                         rd_owned_ff;
   logic [dha_pkg::OWNER_W-1:0]  rd_owner_ff;
   logic [IDX_W-1:0]             wr_idx;
   logic [IDX_W-1:0]             rd_idx;

   assign wr_idx = store_cmd.wr_idx[IDX_W-1:0];
   assign rd_idx = store_cmd.rd_idx[IDX_W-1:0];

   always_comb begin
      owned_in = owned_ff;
      if (store_cmd.clear_all) begin
         owned_in = '0;
      end else if (store_cmd.mark) begin
         owned_in[wr_idx] = 1'b1;
      end else if (store_cmd.clear_one) begin
         owned_in[wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owned_ff <= '0;
      end else begin
         owned_ff <= owned_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_cmd.mark) begin
         owner_mem[wr_idx] <= store_cmd.wr_owner;
      end
      rd_owner_ff <= owner_mem[rd_idx];
      rd_owned_ff <= owned_ff[rd_idx];
   end

   assign store_rsp.owned = rd_owned_ff;
   assign store_rsp.owner = rd_owner_ff;

endmodule

// ===== hdl/decoder_handle_allocator_core.sv =====
// decoder handle allocator: sequencer walking the slot table one slot per step
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  operation, owner, stream flags, query handle
//   rsp      out        rsp_valid / rsp_ready  status, four handles, found owner
//
// each slot visited takes a read issue step and a check step through the one slot store port.
// register: probes slots in up to three searches, plus an owner free pass over
// every slot when a search fails, then a finish step.
// delete of an owned handle: a query probe, then the owner free pass over every slot.
// reset is synchronous and empties every slot at once; req_ready is high only when idle.
// a finished item waits in the output register while the next item is taken.
module decoder_handle_allocator_core #(
   parameter int unsigned LAST_HANDLE = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_owner_id,
   input  logic       req_has_demux,
   input  logic       req_has_video,
   input  logic       req_has_audio,
   input  logic [3:0] req_query_handle,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_base_handle,
   output logic [3:0] rsp_demux_handle,
   output logic [3:0] rsp_video_handle,
   output logic [3:0] rsp_audio_handle,
   output logic [7:0] rsp_found_owner
);

   localparam int unsigned IDX_W = $clog2(LAST_HANDLE + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      P_BASE,
      P_DEMUX,
      P_VIDEO,
      P_QUERY,
      P_FREE
   } phase_type;

   state_type                     state_ff, state_in;
   phase_type                     phase_ff, phase_in;
   dha_pkg::op_type               op_ff, op_in;
   dha_pkg::status_type           status_ff, status_in;
   logic [dha_pkg::OWNER_W-1:0]   owner_ff, owner_in;
   logic                          demux_ff, demux_in;
   logic                          video_ff, video_in;
   logic                          audio_ff, audio_in;
   logic [IDX_W-1:0]              scan_ff, scan_in;
   logic [dha_pkg::HANDLE_W-1:0]  base_ff, base_in;
   logic [dha_pkg::HANDLE_W-1:0]  dmx_ff, dmx_in;
   logic [dha_pkg::HANDLE_W-1:0]  vid_ff, vid_in;
   logic [dha_pkg::HANDLE_W-1:0]  aud_ff, aud_in;
   logic [dha_pkg::OWNER_W-1:0]   found_ff, found_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;
   logic [dha_pkg::HANDLE_W-1:0]  rsp_base_ff, rsp_base_in;
   logic [dha_pkg::HANDLE_W-1:0]  rsp_dmx_ff, rsp_dmx_in;
   logic [dha_pkg::HANDLE_W-1:0]  rsp_vid_ff, rsp_vid_in;
   logic [dha_pkg::HANDLE_W-1:0]  rsp_aud_ff, rsp_aud_in;
   logic [dha_pkg::OWNER_W-1:0]   rsp_found_ff, rsp_found_in;

   dha_pkg::store_cmd_type        store_cmd;
   dha_pkg::store_rsp_type        store_rsp;
   dha_pkg::op_type               req_op;
   logic                          query_in_range;
   logic                          scan_last;
   logic [dha_pkg::HANDLE_W-1:0]  scan_handle;

   dha_slot_store #(
      .LAST_HANDLE (LAST_HANDLE)
   ) u_slot_store (
      .clock     (clock),
      .reset     (reset),
      .store_cmd (store_cmd),
      .store_rsp (store_rsp)
   );

   assign req_op         = dha_pkg::op_type'(req_operation);
   assign query_in_range = 9'(req_query_handle) <= 9'(LAST_HANDLE);
   assign scan_last      = scan_ff == IDX_W'(LAST_HANDLE);
   assign scan_handle    = dha_pkg::HANDLE_W'(scan_ff);
   assign req_ready      = state_ff == S_IDLE;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      owner_in      = owner_ff;
      demux_in      = demux_ff;
      video_in      = video_ff;
      audio_in      = audio_ff;
      scan_in       = scan_ff;
      base_in       = base_ff;
      dmx_in        = dmx_ff;
      vid_in        = vid_ff;
      aud_in        = aud_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_base_in   = rsp_base_ff;
      rsp_dmx_in    = rsp_dmx_ff;
      rsp_vid_in    = rsp_vid_ff;
      rsp_aud_in    = rsp_aud_ff;
      rsp_found_in  = rsp_found_ff;

      store_cmd           = '0;
      store_cmd.wr_idx    = dha_pkg::SLOT_IDX_W'(scan_ff);
      store_cmd.rd_idx    = dha_pkg::SLOT_IDX_W'(scan_ff);
      store_cmd.wr_owner  = owner_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               owner_in  = req_owner_id;
               demux_in  = req_has_demux;
               video_in  = req_has_video;
               audio_in  = req_has_audio;
               status_in = dha_pkg::STATUS_OK;
               base_in   = '0;
               dmx_in    = '0;
               vid_in    = '0;
               aud_in    = '0;
               found_in  = '0;
               unique case (req_op)
                  dha_pkg::OP_REGISTER: begin
                     phase_in = P_BASE;
                     scan_in  = IDX_W'(dha_pkg::FIRST_HANDLE);
                     state_in = S_READ;
                  end
                  dha_pkg::OP_DELETE: begin
                     phase_in = P_QUERY;
                     if (query_in_range) begin
                        scan_in  = IDX_W'(req_query_handle);
                        state_in = S_READ;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  dha_pkg::OP_LOOKUP: begin
                     phase_in = P_QUERY;
                     if (query_in_range) begin
                        scan_in  = IDX_W'(req_query_handle);
                        state_in = S_READ;
                     end else begin
                        status_in = dha_pkg::STATUS_BAD_HANDLE;
                        state_in  = S_DONE;
                     end
                  end
                  dha_pkg::OP_CLEAR: begin
                     store_cmd.clear_all = 1'b1;
                     state_in            = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_READ: begin
            state_in = S_CHECK;
         end

         S_CHECK: begin
            if (phase_ff == P_FREE) begin
               if (store_rsp.owned && store_rsp.owner == owner_ff) begin
                  store_cmd.clear_one = 1'b1;
               end
               if (scan_last) begin
                  state_in = S_DONE;
               end else begin
                  scan_in  = IDX_W'(scan_ff + 1'b1);
                  state_in = S_READ;
               end
            end else if (phase_ff == P_QUERY) begin
               state_in = S_DONE;
               if (store_rsp.owned) begin
                  if (op_ff == dha_pkg::OP_DELETE) begin
                     owner_in = store_rsp.owner;
                     phase_in = P_FREE;
                     scan_in  = '0;
                     state_in = S_READ;
                  end else begin
                     found_in = store_rsp.owner;
                  end
               end else if (op_ff == dha_pkg::OP_LOOKUP) begin
                  status_in = dha_pkg::STATUS_BAD_HANDLE;
               end
            end else if (!store_rsp.owned) begin
               // free slot found at scan_ff
               state_in = S_DONE;
               unique case (phase_ff)
                  P_BASE: begin
                     store_cmd.mark = 1'b1;
                     base_in        = scan_handle;
                     if (demux_ff) begin
                        dmx_in   = scan_handle;
                        phase_in = P_DEMUX;
                        scan_in  = IDX_W'(dha_pkg::FIRST_HANDLE);
                        state_in = S_READ;
                     end else if (video_ff) begin
                        vid_in   = scan_handle;
                        phase_in = P_VIDEO;
                        scan_in  = IDX_W'(dha_pkg::FIRST_HANDLE);
                        state_in = S_READ;
                     end else if (audio_ff) begin
                        aud_in = scan_handle;
                     end
                  end
                  P_DEMUX: begin
                     if (video_ff) begin
                        store_cmd.mark = 1'b1;
                        vid_in         = scan_handle;
                        phase_in       = P_VIDEO;
                        scan_in        = IDX_W'(dha_pkg::FIRST_HANDLE);
                        state_in       = S_READ;
                     end else if (audio_ff) begin
                        store_cmd.mark = 1'b1;
                        aud_in         = scan_handle;
                     end
                  end
                  P_VIDEO: begin
                     if (audio_ff) begin
                        store_cmd.mark = 1'b1;
                        aud_in         = scan_handle;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (scan_last) begin
               // table full: drop everything this owner holds
               status_in = dha_pkg::STATUS_NO_HANDLES;
               base_in   = '0;
               dmx_in    = '0;
               vid_in    = '0;
               aud_in    = '0;
               phase_in  = P_FREE;
               scan_in   = '0;
               state_in  = S_READ;
            end else begin
               scan_in  = IDX_W'(scan_ff + 1'b1);
               state_in = S_READ;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_base_in   = base_ff;
               rsp_dmx_in    = dmx_ff;
               rsp_vid_in    = vid_ff;
               rsp_aud_in    = aud_ff;
               rsp_found_in  = found_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= P_BASE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      status_ff     <= status_in;
      owner_ff      <= owner_in;
      demux_ff      <= demux_in;
      video_ff      <= video_in;
      audio_ff      <= audio_in;
      scan_ff       <= scan_in;
      base_ff       <= base_in;
      dmx_ff        <= dmx_in;
      vid_ff        <= vid_in;
      aud_ff        <= aud_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_dmx_ff    <= rsp_dmx_in;
      rsp_vid_ff    <= rsp_vid_in;
      rsp_aud_ff    <= rsp_aud_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_base_handle  = rsp_base_ff;
   assign rsp_demux_handle = rsp_dmx_ff;
   assign rsp_video_handle = rsp_vid_ff;
   assign rsp_audio_handle = rsp_aud_ff;
   assign rsp_found_owner  = rsp_found_ff;

`ifndef NO_ASSERTIONS
   a_no_mark_and_clear: assert property (@(posedge clock) disable iff (reset)
      !(store_cmd.mark && (store_cmd.clear_one || store_cmd.clear_all)))
      else $error("slot mark and slot clear in the same cycle");

   a_fail_has_no_handles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dha_pkg::STATUS_NO_HANDLES |->
         rsp_base_handle == '0 && rsp_demux_handle == '0 &&
         rsp_video_handle == '0 && rsp_audio_handle == '0)
      else $error("failed registration carries a handle");

   a_store_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      store_cmd.mark || store_cmd.clear_one |-> state_ff == S_CHECK)
      else $error("slot table written outside a check step");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ || state_ff == S_CHECK |-> scan_ff <= IDX_W'(LAST_HANDLE))
      else $error("slot scan beyond the table");
`endif

endmodule
